FILE: rtl/aes_block_cipher_core_assert.svh
// Assertion macros shared by the AES core checker.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES_BLOCK_CIPHER_CORE_ASSERT_SVH
// Assert an implication on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert a next-cycle implication outside reset.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/aes_pkg.sv
// Package for the AES core: types, constants and byte-level GF functions.
// No dependencies.
package aes_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_WORD0  = 3'd1,
    REG_KEY_WORD1  = 3'd2,
    REG_KEY_WORD2  = 3'd3,
    REG_KEY_WORD3  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KEYLEN_128 = 2'd0,
    KEYLEN_192 = 2'd1,
    KEYLEN_256 = 2'd2
  } keylen_t;

  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [7:0] GF_TOPBIT = 8'h80;

  // Controller to datapath commands
  typedef struct packed {
    logic load_block;   // capture block and op
    logic key_load;     // write key words from registers
    logic key_step;     // derive one schedule word
    logic rk_read;      // fetch one round key word
    logic rk_lat;       // latch fetched word into round key buffer
    logic round_first;  // apply initial add round key
    logic round_mid;    // full round
    logic round_last;   // final round
  } dp_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ ((a & GF_TOPBIT) != 8'h00 ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] bs;
    r = 8'h01;
    bs = x;
    for (int i = 0; i < 8; i++) begin
      if (((8'd254 >> i) & 8'h01) != 8'h00) r = gmul(r, bs);
      bs = gmul(bs, bs);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned n);
    rotl8 = 8'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] i;
    i = ginv(x);
    sbox_calc = i ^ rotl8(i, 1) ^ rotl8(i, 2) ^ rotl8(i, 3) ^ rotl8(i, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] y);
    isbox_calc = ginv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
  endfunction

  // Tables built at elaboration
  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t make_sbox(input logic inv);
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_t SBOX = make_sbox(1'b0);
  localparam sbox_t ISBOX = make_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: rtl/aes_if.sv
// Valid/ready channel interface carrying a payload.
// No dependencies.
interface aes_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/aes_ctrl.sv
// Sequencer for key expansion and rounds of the AES core.
// Depends on aes_pkg.
module aes_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           key_length,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aes_pkg::dp_cmd_t     cmd,
  output logic [5:0]           widx,
  output logic [1:0]           wsel,
  output logic [3:0]           nk_o,
  output logic [3:0]           rnd_o
);
  import aes_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KLOAD = 7'b0000010,
    S_KEXP  = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_LATCH = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [5:0] cnt;
  logic [1:0] col;
  logic [3:0] rnd;
  logic [3:0] nr;
  logic [3:0] nk;
  logic [5:0] total;

  assign nk = (key_length == KEYLEN_128) ? 4'd4 : ((key_length == KEYLEN_192) ? 4'd6 : 4'd8);
  assign nr = nk + 4'd6;
  assign total = {nr, 2'b00} + 6'd4;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_DONE;
  assign widx = cnt;
  assign wsel = col;
  assign nk_o = nk;
  assign rnd_o = rnd;

  // Decode the state into datapath commands
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_block = 1'b1;
          state_next = S_KLOAD;
        end
      end
      S_KLOAD: begin
        cmd.key_load = 1'b1;
        if (cnt == 6'(nk) - 6'd1) state_next = S_KEXP;
      end
      S_KEXP: begin
        cmd.key_step = 1'b1;
        if (cnt == total - 6'd1) state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.rk_read = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.rk_lat = 1'b1;
        if (col == 2'd3) state_next = S_ROUND;
        else state_next = S_FETCH;
      end
      S_ROUND: begin
        if (rnd == 4'd0) cmd.round_first = 1'b1;
        else if (rnd == nr) cmd.round_last = 1'b1;
        else cmd.round_mid = 1'b1;
        state_next = (rnd == nr) ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      col <= '0;
      rnd <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          col <= '0;
          rnd <= '0;
        end
        S_KLOAD, S_KEXP: cnt <= (state_next == S_FETCH) ? 6'd0 : cnt + 6'd1;
        S_LATCH: col <= col + 2'd1;
        S_ROUND: rnd <= rnd + 4'd1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/aes_dp.sv
// Datapath of the AES core: round key memory, schedule and round logic.
// Depends on aes_pkg.
module aes_dp #(
  parameter int unsigned RoundKeyWords = 60
) (
  input  logic             clk,
  input  aes_pkg::dp_cmd_t cmd,
  input  logic [5:0]       widx,
  input  logic [1:0]       wsel,
  input  logic [3:0]       nk,
  input  logic [3:0]       rnd,
  input  logic [63:0]      key_word [4],
  input  logic             operation,
  input  logic [127:0]     block_in,
  output logic [127:0]     block_out
);
  import aes_pkg::*;

  localparam int unsigned AW = $clog2(RoundKeyWords);

  logic [31:0]  mem [RoundKeyWords];
  logic [31:0]  rdata;
  logic [31:0]  wdata;
  logic         wen;
  logic [31:0]  hist [8];
  logic [7:0]   rcon;
  logic [3:0]   pos;
  logic [127:0] st;
  logic [127:0] rk;
  logic         dec;
  logic [3:0]   nr;
  logic [5:0]   ridx;
  logic [31:0]  t;
  logic [31:0]  kw;

  assign nr = nk + 4'd6;

  // Key word from registers
  assign kw = widx[0] ? key_word[widx[2:1]][31:0] : key_word[widx[2:1]][63:32];

  // Schedule step: hist[0] is word i-1, hist[nk-1] is word i-nk
  always_comb begin
    t = hist[0];
    if (pos == 4'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && pos == 4'd4) t = sub_word(t);
    wdata = cmd.key_load ? kw : (hist[3'(nk - 4'd1)] ^ t);
  end
  assign wen = (cmd.key_load || cmd.key_step) && (32'(widx) < RoundKeyWords);

  // Round being done and its key word address
  always_comb begin
    logic [3:0] r;
    r = dec ? (nr - rnd) : rnd;
    ridx = {r, wsel};
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wen) mem[AW'(widx)] <= wdata;
    if (cmd.rk_read) rdata <= (32'(ridx) < RoundKeyWords) ? mem[AW'(ridx)] : 32'h0;
  end

  // Schedule history (words past the store read as zero), position and round constant
  always_ff @(posedge clk) begin
    if (cmd.key_load || cmd.key_step) begin
      hist[0] <= wen ? wdata : 32'h0;
      for (int i = 1; i < 8; i++) hist[i] <= hist[i-1];
    end
    if (cmd.key_load) begin
      pos <= 4'd0;
      rcon <= 8'h01;
    end else if (cmd.key_step) begin
      pos <= (pos == nk - 4'd1) ? 4'd0 : pos + 4'd1;
      if (pos == 4'd0) rcon <= xtime(rcon);
    end
    if (cmd.rk_lat) rk <= {rk[95:0], rdata};
  end

  // Round functions on the state, byte 0 most significant, column-major
  function automatic logic [127:0] shrows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
        else o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
      end
    shrows = o;
  endfunction

  function automatic logic [127:0] subb(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++)
      o[8*i +: 8] = inv ? ISBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
    subb = o;
  endfunction

  function automatic logic [127:0] mixc(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      if (inv) begin
        o[127-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        o[119-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
        o[111-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
        o[103-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
      end else begin
        o[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    mixc = o;
  endfunction

  // Load the block and op, then update the state once per round
  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      st <= block_in;
      dec <= operation;
    end else if (cmd.round_first) begin
      st <= st ^ rk;
    end else if (cmd.round_mid) begin
      if (dec) st <= mixc(subb(shrows(st, 1'b1), 1'b1) ^ rk, 1'b1);
      else st <= mixc(shrows(subb(st, 1'b0), 1'b0), 1'b0) ^ rk;
    end else if (cmd.round_last) begin
      if (dec) st <= subb(shrows(st, 1'b1), 1'b1) ^ rk;
      else st <= shrows(subb(st, 1'b0), 1'b0) ^ rk;
    end
  end

  assign block_out = st;

endmodule

FILE: rtl/aes_block_cipher_core.sv
// Top level of the AES-128/192/256 core: registers, controller, datapath.
// Depends on aes_pkg, aes_if, aes_ctrl, aes_dp.
//
// channel   direction  payload
// in_ch     sink       operation, block_high, block_low
// out_ch    source     result_high, result_low
// cfg       write      cfg_we, cfg_index, cfg_data
//
// After the input transfer the key is expanded at one word per cycle into 4*(Nr+1)
// words, then Nr+1 rounds follow: four fetch/latch pairs through the registered
// round key read, then the round itself. One block at a time: input ready is high
// only when idle, so a held result stalls the input.
// Synchronous reset clears control and key registers; the key memory is not cleared.
module aes_block_cipher_core #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aes_pkg::CfgDataW-1:0] cfg_data,
  aes_if.sink                         in_ch,
  aes_if.source                       out_ch
);
  import aes_pkg::*;

  logic [1:0]  key_length;
  logic [63:0] key_word [4];
  dp_cmd_t     cmd;
  logic [5:0]  widx;
  logic [1:0]  wsel;
  logic [3:0]  nk;
  logic [3:0]  rnd;
  logic [127:0] res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length <= cfg_data[1:0];
        REG_KEY_WORD0:  key_word[0] <= cfg_data;
        REG_KEY_WORD1:  key_word[1] <= cfg_data;
        REG_KEY_WORD2:  key_word[2] <= cfg_data;
        REG_KEY_WORD3:  key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk, .rst, .key_length,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .widx, .wsel, .nk_o(nk), .rnd_o(rnd)
  );

  aes_dp #(.RoundKeyWords(ROUND_KEY_WORDS)) u_dp (
    .clk, .cmd, .widx, .wsel, .nk, .rnd, .key_word,
    .operation(in_ch.data.operation),
    .block_in({in_ch.data.block_high, in_ch.data.block_low}),
    .block_out(res)
  );

  assign out_ch.data.result_high = res[127:64];
  assign out_ch.data.result_low = res[63:0];

endmodule

FILE: rtl/aes_block_cipher_core_chk.sv
// Port-level checker for the AES core, bound to the top level.
// Depends on aes_block_cipher_core_assert.svh.
`include "aes_block_cipher_core_assert.svh"
module aes_block_cipher_core_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `AES_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready, "ready while result pending")
  `AES_ASSERT_NEXT(a_accept, clk, rst, in_valid && in_ready, !out_valid, "instant result")
  `AES_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind aes_block_cipher_core aes_block_cipher_core_chk u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

FILE: tb/sv/aes_tb_pkg.sv
`timescale 1ns / 1ps
// Transfer payload types and operation codes for the AES core testbench.
// Depends on nothing; used by the checker and the testbench top.
package aes_tb_pkg;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } blk_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } blk_out_t;

endpackage

FILE: tb/sv/aes_block_cipher_checker.sv
`timescale 1ns / 1ps
// Checker for the AES core: tracks register writes, predicts each result
// and compares it with the output transfers. Depends on aes_pkg, aes_tb_pkg.
module aes_block_cipher_checker
  import aes_pkg::*;
  import aes_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  blk_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  blk_out_t           out_data,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);

  localparam logic [7:0] POLY_LOW = 8'h1b;
  localparam logic [7:0] AFFINE_C = 8'h63;

  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];
  logic [1:0]  key_len;
  logic [63:0] key_word [4];
  blk_out_t    pending_results [$];

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  // Build both substitution tables from the field inverse
  initial begin
    logic [7:0] inv, s, base;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = 8'(x);
      for (int e = 0; e < 8; e++) begin
        if (e != 0) inv = fmul(inv, base);
        base = fmul(base, base);
      end
      s = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ AFFINE_C;
      fwd_sbox[x] = s;
      rev_sbox[s] = 8'(x);
    end
  end

  function automatic logic [31:0] sub_wd(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] s, input logic inv);
    for (int i = 0; i < 16; i++)
      s[127-8*i -: 8] = inv ? rev_sbox[s[127-8*i -: 8]] : fwd_sbox[s[127-8*i -: 8]];
    return s;
  endfunction

  // Byte 4c+r holds row r of column c
  function automatic logic [127:0] shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src, dst;
    t = '0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inv ? r + 4 * c : r + 4 * ((c + r) % 4);
        dst = inv ? r + 4 * ((c + r) % 4) : r + 4 * c;
        t[127-8*dst -: 8] = s[127-8*src -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [7:0] m [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= fmul(m[(k + 4 - r) % 4], col[k]);
        s[127-8*(4*c+r) -: 8] = v;
      end
    end
    return s;
  endfunction

  // Expand the key and run the forward or inverse cipher on one block
  function automatic logic [127:0] aes_transform(input logic dec, input logic [127:0] blk);
    logic [31:0]  w [60];
    logic [127:0] rk [15];
    logic [31:0]  t;
    logic [63:0]  k;
    logic [7:0]   rc;
    logic [127:0] s;
    int nk, nr;
    nk = (key_len == KEYLEN_128) ? 4 : (key_len == KEYLEN_192) ? 6 : 8;
    nr = nk + 6;
    for (int i = 0; i < nk; i++) begin
      k = key_word[i / 2];
      w[i] = (i % 2) ? k[31:0] : k[63:32];
    end
    rc = 8'h01;
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_wd({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_wd(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= nr; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    s = blk;
    if (!dec) begin
      s ^= rk[0];
      for (int r = 1; r < nr; r++) s = mix(shift(subst(s, 1'b0), 1'b0), 1'b0) ^ rk[r];
      s = shift(subst(s, 1'b0), 1'b0) ^ rk[nr];
    end else begin
      s ^= rk[nr];
      for (int r = nr - 1; r >= 1; r--) s = mix(subst(shift(s, 1'b1), 1'b1) ^ rk[r], 1'b1);
      s = subst(shift(s, 1'b1), 1'b1) ^ rk[0];
    end
    return s;
  endfunction

  assign outstanding = pending_results.size();

  // Track register writes, queue predictions, compare output transfers
  always @(posedge clk) begin
    blk_out_t want;
    blk_out_t fresh;
    logic [127:0] r;
    if (rst) begin
      key_len <= KEYLEN_128;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      pending_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LENGTH: key_len <= cfg_data[1:0];
          REG_KEY_WORD0:  key_word[0] <= cfg_data;
          REG_KEY_WORD1:  key_word[1] <= cfg_data;
          REG_KEY_WORD2:  key_word[2] <= cfg_data;
          REG_KEY_WORD3:  key_word[3] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        r = aes_transform(in_data.operation == OP_DECRYPT,
                          {in_data.block_high, in_data.block_low});
        fresh.result_high = r[127:64];
        fresh.result_low = r[63:0];
        pending_results = {pending_results, fresh};
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %h_%h with nothing expected", $realtime,
                     out_data.result_high, out_data.result_low);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.result_high !== out_data.result_high ||
              want.result_low !== out_data.result_low) begin
            if (mismatches < 10)
              $display("%0t: result_high exp %h got %h, result_low exp %h got %h",
                       $realtime, want.result_high, out_data.result_high,
                       want.result_low, out_data.result_low);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/aes_block_cipher_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the AES core: clock, reset, key setup, block stimulus,
// output back-pressure and verdict. Depends on aes_pkg, aes_tb_pkg, aes_if, checker.
module aes_block_cipher_core_tb;
  import aes_pkg::*;
  import aes_tb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_BLOCKS = 160;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         mismatches;
  int unsigned         outstanding;
  int unsigned         cycles;
  logic                calm_sender;
  logic                hold_request;

  aes_if #(.payload_t(blk_in_t))  in_ch ();
  aes_if #(.payload_t(blk_out_t)) out_ch ();

  aes_block_cipher_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  aes_block_cipher_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // End the run if it hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    int unsigned stall;
    bit calm;
    bit held;
    out_ch.ready = 1'b0;
    stall = 0;
    held = 0;
    calm = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cycles % 1000 == 0) calm = $urandom_range(0, 2) == 0;
      if (hold_request && !held) begin
        held = 1;
        stall = 600;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic write_raw_index(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one block and hold it until the transfer
  task automatic send_block(input op_t op, input logic [63:0] hi, input logic [63:0] lo);
    int unsigned gap;
    gap = calm_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{operation: op, block_high: hi, block_low: lo};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and let the core drain before touching the key
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] kl, input int unsigned style);
    logic [63:0] kw;
    // Upper bits of the key length write are noise
    write_reg(REG_KEY_LENGTH, (rand64() & ~64'h3) | {62'h0, kl});
    for (int i = 0; i < 4; i++) begin
      kw = (style == 0) ? 64'h0 : (style == 1) ? '1 : rand64();
      write_reg(reg_idx_t'(REG_KEY_WORD0 + i), kw);
    end
    // Indexes past the last register must be ignored
    write_raw_index(3'd5 + 3'($urandom_range(0, 2)), rand64());
    end_writes();
  endtask

  initial begin
    logic [63:0] edge_vals [6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    calm_sender = 1'b0;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key, then field extremes under each key length
    edge_vals = '{64'h0, '1, 64'h0123456789abcdef, 64'haaaaaaaaaaaaaaaa,
                  64'h5555555555555555, 64'h8000000000000001};
    for (int i = 0; i < 6; i++) send_block(OP_ENCRYPT, edge_vals[i], edge_vals[5-i]);
    for (int i = 0; i < 6; i++) send_block(OP_DECRYPT, edge_vals[5-i], edge_vals[i]);
    drain();
    for (int kl = 1; kl < 4; kl++) begin
      load_key(2'(kl), 2);
      send_block(OP_ENCRYPT, '1, 64'h0);
      send_block(OP_DECRYPT, 64'h0, '1);
      send_block(OP_ENCRYPT, rand64(), rand64());
      drain();
    end

    // Random: key setting per phase, extremes among them
    for (int ph = 0; ph < PHASES; ph++) begin
      load_key(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)), ph < 3 ? ph : 2);
      calm_sender <= (ph % 3 == 2);
      if (ph == 1) hold_request <= 1'b1;
      for (int n = 0; n < PHASE_BLOCKS; n++)
        send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, rand64(), rand64());
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_if.sv
rtl/aes_ctrl.sv
rtl/aes_dp.sv
rtl/aes_block_cipher_core.sv
rtl/aes_block_cipher_core_chk.sv
tb/sv/aes_tb_pkg.sv
tb/sv/aes_block_cipher_checker.sv
tb/sv/aes_block_cipher_core_tb.sv
